FILE: sv/two_level_thread_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Two-level thread scheduler: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_THREAD_SCHEDULER_TOP_DEFINES_SVH
`define TWO_LEVEL_THREAD_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TLTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TLTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tlts_pkg.sv
// ----------------------------------------------------------------------------
// tlts_pkg
// Shared constants, codes and types of the two-level thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlts_pkg;

    localparam int NUM_THREADS = 16;
    localparam int SLOT_W      = $clog2(NUM_THREADS);
    localparam int CNT_W       = $clog2(NUM_THREADS + 1);

    localparam int QUANT_W       = 16;
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd100;

    localparam int CMD_W      = 3;
    localparam int OUT_SLOT_W = 4;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 16;

    // queue indexes
    localparam int NUM_Q   = 3;
    localparam int Q_HIGH  = 0;
    localparam int Q_LOW   = 1;
    localparam int Q_BLOCK = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_BLOCK  = 3'd2,
        CMD_DISK   = 3'd3,
        CMD_EXIT   = 3'd4
    } cmd_t;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;   // capture the input beat
        logic commit;  // apply the command, load the result register
    } ctrl_t;

endpackage

`default_nettype wire

FILE: sv/tlts_ram.sv
// ----------------------------------------------------------------------------
// tlts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/tlts_ctrl.sv
// ----------------------------------------------------------------------------
// tlts_ctrl
// Command sequencer: accept, queue-head read, execute, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tlts_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output tlts_pkg::ctrl_t     ctrl
);

    import tlts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_valid_reg;
    assign out_free    = !m_valid_reg || m_tready;
    assign ctrl.latch  = s_tvalid && (state_reg == ST_IDLE);
    assign ctrl.commit = (state_reg == ST_EXEC) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tlts_dp.sv
// ----------------------------------------------------------------------------
// tlts_dp
// Scheduler datapath: slot table, three queues in RAM, running-thread state.
// ----------------------------------------------------------------------------
`default_nettype none

module tlts_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tlts_pkg::ctrl_t               ctrl,
    input  wire logic [tlts_pkg::IN_W-1:0]     in_data,
    input  wire logic                          cfg_we,
    input  wire logic [tlts_pkg::QUANT_W-1:0]  cfg_data,
    output logic      [tlts_pkg::OUT_W-1:0]    out_data
);

    import tlts_pkg::*;

    // captured command
    logic [CMD_W-1:0]   cmd_reg;
    logic               prio_reg;
    logic [QUANT_W-1:0] quantum_reg;

    // slot table
    logic [NUM_THREADS-1:0] free_reg, free_next;
    logic [NUM_THREADS-1:0] high_reg, high_next;

    // queue pointers
    logic [SLOT_W-1:0] head_reg  [NUM_Q];
    logic [SLOT_W-1:0] head_next [NUM_Q];
    logic [CNT_W-1:0]  count_reg [NUM_Q];
    logic [CNT_W-1:0]  count_next[NUM_Q];
    logic [SLOT_W:0]   tail_sum  [NUM_Q];
    logic [SLOT_W-1:0] tail      [NUM_Q];

    // running thread
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic               cur_high_reg, cur_high_next;
    logic               idle_reg, idle_next;
    logic [QUANT_W-1:0] ticks_reg, ticks_next;
    logic               fin_reg, fin_next;

    // queue RAM ports
    logic              wr_en    [NUM_Q];
    logic [SLOT_W-1:0] rd_data  [NUM_Q];

    // per-command control
    logic              push     [NUM_Q];
    logic              push_ok  [NUM_Q];
    logic [SLOT_W-1:0] push_data[NUM_Q];
    logic              pop      [NUM_Q];
    logic              rotate;
    logic              dispatch;
    logic              switched;
    logic [SLOT_W-1:0] created;
    logic              failed;

    logic               running_low;
    logic               any_ready;
    logic [QUANT_W-1:0] reload;
    logic [SLOT_W-1:0]  free_idx;
    logic               free_found;
    logic [SLOT_W-1:0]  blk_slot;

    logic [OUT_SLOT_W-1:0] run_field;
    logic [OUT_W-1:0]      out_next;

    assign running_low = !idle_reg && !cur_high_reg;
    assign any_ready   = (count_reg[Q_HIGH] != '0) || (count_reg[Q_LOW] != '0);
    assign reload      = (quantum_reg == '0) ? QUANTUM_RESET / QUANTUM_RESET : quantum_reg;
    assign blk_slot    = rd_data[Q_BLOCK];

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_THREADS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // command decode and dispatch
    always_comb
    begin
        for (int q = 0; q < NUM_Q; q++)
        begin
            push[q]      = 1'b0;
            push_data[q] = '0;
            pop[q]       = 1'b0;
        end
        rotate        = 1'b0;
        dispatch      = 1'b0;
        switched      = 1'b0;
        created       = '0;
        failed        = 1'b0;
        free_next     = free_reg;
        high_next     = high_reg;
        cur_next      = cur_reg;
        cur_high_next = cur_high_reg;
        idle_next     = idle_reg;
        ticks_next    = ticks_reg;
        fin_next      = fin_reg;

        if (fin_reg)
        begin
            failed = (cmd_reg == CMD_CREATE);
        end
        else
        begin
            unique case (cmd_reg)
                CMD_TICK:
                begin
                    if (idle_reg)
                    begin
                        if (any_ready)
                        begin
                            dispatch = 1'b1;
                            switched = 1'b1;
                        end
                    end
                    else if (running_low)
                    begin
                        if (ticks_reg <= QUANT_W'(1))
                        begin
                            ticks_next = reload;
                            rotate     = any_ready;
                            switched   = any_ready;
                        end
                        else
                        begin
                            ticks_next = ticks_reg - QUANT_W'(1);
                        end
                    end
                end
                CMD_CREATE:
                begin
                    if (!free_found)
                    begin
                        failed = 1'b1;
                    end
                    else
                    begin
                        created             = free_idx;
                        free_next[free_idx] = 1'b0;
                        high_next[free_idx] = prio_reg;
                        if (prio_reg)
                        begin
                            push[Q_HIGH]      = 1'b1;
                            push_data[Q_HIGH] = free_idx;
                            rotate            = running_low;
                            switched          = running_low;
                        end
                        else
                        begin
                            push[Q_LOW]      = 1'b1;
                            push_data[Q_LOW] = free_idx;
                        end
                    end
                end
                CMD_BLOCK:
                begin
                    if (!idle_reg)
                    begin
                        push[Q_BLOCK]      = 1'b1;
                        push_data[Q_BLOCK] = cur_reg;
                        dispatch           = 1'b1;
                        switched           = 1'b1;
                    end
                end
                CMD_DISK:
                begin
                    if (count_reg[Q_BLOCK] != '0)
                    begin
                        pop[Q_BLOCK] = 1'b1;
                        if (high_reg[blk_slot])
                        begin
                            push[Q_HIGH]      = 1'b1;
                            push_data[Q_HIGH] = blk_slot;
                            rotate            = running_low;
                            switched          = running_low;
                        end
                        else
                        begin
                            push[Q_LOW]      = 1'b1;
                            push_data[Q_LOW] = blk_slot;
                        end
                    end
                end
                CMD_EXIT:
                begin
                    if (!idle_reg)
                    begin
                        free_next[cur_reg] = 1'b1;
                        switched           = 1'b1;
                        if (!any_ready && (count_reg[Q_BLOCK] == '0))
                        begin
                            fin_next  = 1'b1;
                            idle_next = 1'b1;
                            cur_next  = '0;
                        end
                        else
                        begin
                            dispatch = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // preempted low thread goes to the low tail
        if (rotate)
        begin
            push[Q_LOW]      = 1'b1;
            push_data[Q_LOW] = cur_reg;
            dispatch         = 1'b1;
        end

        for (int q = 0; q < NUM_Q; q++)
        begin
            push_ok[q] = push[q] && (count_reg[q] != CNT_W'(NUM_THREADS));
        end

        // next ready thread; an empty queue hands over the beat's own push
        if (dispatch)
        begin
            ticks_next = reload;
            if ((count_reg[Q_HIGH] != '0) || push_ok[Q_HIGH])
            begin
                pop[Q_HIGH]   = 1'b1;
                cur_next      = (count_reg[Q_HIGH] == '0) ? push_data[Q_HIGH]
                                                           : rd_data[Q_HIGH];
                cur_high_next = 1'b1;
                idle_next     = 1'b0;
            end
            else if ((count_reg[Q_LOW] != '0) || push_ok[Q_LOW])
            begin
                pop[Q_LOW]    = 1'b1;
                cur_next      = (count_reg[Q_LOW] == '0) ? push_data[Q_LOW]
                                                          : rd_data[Q_LOW];
                cur_high_next = 1'b0;
                idle_next     = 1'b0;
            end
            else
            begin
                idle_next = 1'b1;
            end
        end
    end

    // queue pointers
    always_comb
    begin
        for (int q = 0; q < NUM_Q; q++)
        begin
            tail_sum[q] = {1'b0, head_reg[q]} + (SLOT_W + 1)'(count_reg[q]);
            if (tail_sum[q] >= (SLOT_W + 1)'(NUM_THREADS))
            begin
                tail[q] = SLOT_W'(tail_sum[q] - (SLOT_W + 1)'(NUM_THREADS));
            end
            else
            begin
                tail[q] = SLOT_W'(tail_sum[q]);
            end
            wr_en[q] = ctrl.commit && push_ok[q];
            if (pop[q])
            begin
                head_next[q] = (head_reg[q] == SLOT_W'(NUM_THREADS - 1)) ? '0
                                                                         : head_reg[q] + 1'b1;
            end
            else
            begin
                head_next[q] = head_reg[q];
            end
            count_next[q] = count_reg[q] + CNT_W'(push_ok[q]) - CNT_W'(pop[q]);
        end
    end

    tlts_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_THREADS)) u_high_q (
        .clk     (clk),
        .wr_en   (wr_en[Q_HIGH]),
        .wr_addr (tail[Q_HIGH]),
        .wr_data (push_data[Q_HIGH]),
        .rd_addr (head_reg[Q_HIGH]),
        .rd_data (rd_data[Q_HIGH])
    );

    tlts_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_THREADS)) u_low_q (
        .clk     (clk),
        .wr_en   (wr_en[Q_LOW]),
        .wr_addr (tail[Q_LOW]),
        .wr_data (push_data[Q_LOW]),
        .rd_addr (head_reg[Q_LOW]),
        .rd_data (rd_data[Q_LOW])
    );

    tlts_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_THREADS)) u_block_q (
        .clk     (clk),
        .wr_en   (wr_en[Q_BLOCK]),
        .wr_addr (tail[Q_BLOCK]),
        .wr_data (push_data[Q_BLOCK]),
        .rd_addr (head_reg[Q_BLOCK]),
        .rd_data (rd_data[Q_BLOCK])
    );

    // result beat
    assign run_field = idle_next ? '0 : OUT_SLOT_W'(cur_next);
    assign out_next  = OUT_W'({fin_next, failed, OUT_SLOT_W'(created), switched,
                               idle_next, run_field});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg  <= QUANTUM_RESET;
            free_reg     <= {{(NUM_THREADS - 1){1'b1}}, 1'b0};
            high_reg     <= '0;
            for (int q = 0; q < NUM_Q; q++)
            begin
                head_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
            cur_reg      <= '0;
            cur_high_reg <= 1'b0;
            idle_reg     <= 1'b0;
            ticks_reg    <= QUANTUM_RESET;
            fin_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quantum_reg <= cfg_data;
            end
            if (ctrl.commit)
            begin
                free_reg     <= free_next;
                high_reg     <= high_next;
                for (int q = 0; q < NUM_Q; q++)
                begin
                    head_reg[q]  <= head_next[q];
                    count_reg[q] <= count_next[q];
                end
                cur_reg      <= cur_next;
                cur_high_reg <= cur_high_next;
                idle_reg     <= idle_next;
                ticks_reg    <= ticks_next;
                fin_reg      <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg  <= in_data[CMD_W-1:0];
            prio_reg <= in_data[CMD_W];
        end
        if (ctrl.commit)
        begin
            out_data <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/two_level_thread_scheduler_top.sv
// ----------------------------------------------------------------------------
// two_level_thread_scheduler_top
// Hardware thread scheduler: high/low ready queues, blocked queue, quantum.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one beat per scheduler command (tick, create, block
//    running, disk done, exit running) with the create priority.
//  - Output stream (m_*): exactly one result beat per command, in order.
//  - cfg_we/cfg_data write the quantum (ticks per low-priority turn; 0 acts
//    as 1). Write only while no command is in flight.
//  - Flow: once the input beat is taken, the command passes the registered
//    head read of the queue RAMs, then execute, and m_tvalid rises. One
//    command at a time: a new beat is taken only once execute is done.
//  - The result register decouples the sides: the next command is accepted
//    while a result still waits, and execution holds until it is taken, so a
//    stalled receiver stops intake after one more command.
//  - Reset: slot 0 runs (low priority), other slots free, queues empty,
//    quantum 100. Once finished, later commands change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_thread_scheduler_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_tdata: [2:0] cmd, [3] new_priority, [7:4] zero
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tlts_pkg::IN_W-1:0]     s_tdata,
    // m_tdata: [3:0] running_thread, [4] running_is_idle, [5] switched,
    //          [9:6] created_thread, [10] create_failed, [11] all_finished,
    //          [15:12] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [tlts_pkg::OUT_W-1:0]    m_tdata,
    // quantum register
    input  wire logic                          cfg_we,
    input  wire logic [tlts_pkg::QUANT_W-1:0]  cfg_data
);

    import tlts_pkg::*;

    ctrl_t ctrl;

    // sequencer: handshakes and step timing
    tlts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // slot table, queues and running-thread state
    tlts_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_data  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

FILE: sv/tlts_checker.sv
// ----------------------------------------------------------------------------
// tlts_checker
// Port-level assertions for the thread scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_level_thread_scheduler_top_defines.svh"

module tlts_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [tlts_pkg::OUT_W-1:0] m_tdata
);

    // a stalled result beat holds
    `TLTS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // one command at a time
    `TLTS_ASSERT_NXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "input taken while a command is in flight")

    // idle reports slot zero
    `TLTS_ASSERT_IMP(a_idle_slot, m_tvalid && m_tdata[4], m_tdata[3:0] == 4'd0, "idle with nonzero running slot")

    // finished implies idle
    `TLTS_ASSERT_IMP(a_fin_idle, m_tvalid && m_tdata[11], m_tdata[4], "finished but not idle")

    // failed create gives no slot
    `TLTS_ASSERT_IMP(a_fail_slot, m_tvalid && m_tdata[10], m_tdata[9:6] == 4'd0, "failed create reports a slot")

endmodule

bind two_level_thread_scheduler_top tlts_checker u_tlts_checker (.*);

`default_nettype wire
